@@ rtl/core/cpbc_pkg.sv @@
// Shared types, constants and byte/nibble helper functions for the chained
// permutation block cipher. No dependencies; every rtl/core module imports it.
package cpbc_pkg;

   localparam int BlockBytes  = 16;
   localparam int ByteW       = 8;
   localparam int NibW        = 4;
   localparam int BlockW      = BlockBytes * ByteW;
   localparam int PermW       = BlockBytes * NibW;
   localparam int HalfW       = BlockW / 2;
   localparam int ValidW      = 5;
   localparam int RoundW      = 4;
   localparam int CsrIdxW     = 3;
   localparam int CsrDataW    = 64;
   localparam int SumW        = 12;
   localparam int ModBase     = BlockBytes - 3;
   // floor(s * RecipMod / 2^RecipShift) == floor(s / ModBase) for every s < 2^SumW
   localparam int RecipShift  = 16;
   localparam int RecipW      = 13;
   localparam int RecipMod    = 5042;
   localparam int ProdW       = SumW + RecipW;
   localparam int QuotW       = 9;

   localparam logic [PermW-1:0] PermIdentity = 64'hFEDC_BA98_7654_3210;

   localparam logic [CsrIdxW-1:0] CsrKeyLow     = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrKeyHigh    = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrPermTable  = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrRoundCount = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrDecrypt    = 3'd4;

   typedef logic [BlockW-1:0] block_type;
   typedef logic [PermW-1:0]  perm_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic round;
      logic sum;
      logic quot;
      logic rem;
      logic rot;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic full;
   } status_type;

   // y[j] = x[(j + n) mod 16]
   function automatic block_type rotl_bytes(block_type x, logic [RoundW-1:0] n);
      block_type y;
      logic [RoundW-1:0] s;
      for (int j = 0; j < BlockBytes; j++) begin
         s = RoundW'(j) + n;
         y[ByteW*j +: ByteW] = x[ByteW*s +: ByteW];
      end
      return y;
   endfunction

   function automatic perm_type rotl_nibs(perm_type p, logic [RoundW-1:0] n);
      perm_type y;
      logic [RoundW-1:0] s;
      for (int j = 0; j < BlockBytes; j++) begin
         s = RoundW'(j) + n;
         y[NibW*j +: NibW] = p[NibW*s +: NibW];
      end
      return y;
   endfunction

   function automatic block_type fwd_perm(block_type x, perm_type p);
      block_type y;
      logic [NibW-1:0] e;
      for (int i = 0; i < BlockBytes; i++) begin
         e = p[NibW*i +: NibW];
         y[ByteW*i +: ByteW] = x[ByteW*e +: ByteW];
      end
      return y;
   endfunction

   // later entries win where the table repeats a position; unhit bytes stay zero
   function automatic block_type inv_perm(block_type x, perm_type p);
      block_type y;
      logic [NibW-1:0] e;
      y = '0;
      for (int i = 0; i < BlockBytes; i++) begin
         e = p[NibW*i +: NibW];
         y[ByteW*e +: ByteW] = x[ByteW*i +: ByteW];
      end
      return y;
   endfunction

   function automatic block_type mask_block(block_type x, logic [ValidW-1:0] v);
      block_type y;
      y = x;
      for (int j = 0; j < BlockBytes; j++) begin
         if (ValidW'(j) >= v) begin
            y[ByteW*j +: ByteW] = '0;
         end
      end
      return y;
   endfunction

   function automatic logic [SumW-1:0] byte_sum(block_type x);
      logic [SumW-1:0] s_lo;
      logic [SumW-1:0] s_hi;
      s_lo = '0;
      s_hi = '0;
      for (int j = 0; j < BlockBytes / 2; j++) begin
         s_lo = s_lo + SumW'(x[ByteW*j +: ByteW]);
         s_hi = s_hi + SumW'(x[ByteW*(j + BlockBytes/2) +: ByteW]);
      end
      return s_lo + s_hi;
   endfunction

endpackage

@@ rtl/core/cpbc_ctrl.sv @@
// Sequencer for the chained permutation block cipher: one-hot state machine,
// round counter and result valid flag. Depends on cpbc_pkg.
module cpbc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [cpbc_pkg::RoundW-1:0]   rounds_eff,
   input  cpbc_pkg::status_type          status,
   output cpbc_pkg::cmd_type             cmd
);
   import cpbc_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SETUP = 8'b0000_0010,
      ST_ROUND = 8'b0000_0100,
      ST_SUM   = 8'b0000_1000,
      ST_QUOT  = 8'b0001_0000,
      ST_REM   = 8'b0010_0000,
      ST_ROT   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [RoundW-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            if (status.skip) begin
               state_in = ST_DONE;
            end else begin
               cnt_in   = rounds_eff - RoundW'(1);
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (cnt_ff == '0) begin
               state_in = status.full ? ST_SUM : ST_DONE;
            end else begin
               cnt_in = cnt_ff - RoundW'(1);
            end
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_QUOT;
         end
         ST_QUOT: begin
            cmd.quot = 1'b1;
            state_in = ST_REM;
         end
         ST_REM: begin
            cmd.rem  = 1'b1;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            cmd.rot  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to be free or draining this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/cpbc_dp.sv @@
// Datapath for the chained permutation block cipher: block, round key, chain
// and table registers, table-rotation arithmetic and result register. Depends on cpbc_pkg.
module cpbc_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  cpbc_pkg::cmd_type             cmd,
   output cpbc_pkg::status_type          status,
   input  logic [cpbc_pkg::HalfW-1:0]    req_block_low,
   input  logic [cpbc_pkg::HalfW-1:0]    req_block_high,
   input  logic [cpbc_pkg::ValidW-1:0]   req_valid_bytes,
   input  logic                          req_first_block,
   input  logic [cpbc_pkg::HalfW-1:0]    key_low,
   input  logic [cpbc_pkg::HalfW-1:0]    key_high,
   input  cpbc_pkg::perm_type            perm_table,
   input  logic [cpbc_pkg::RoundW-1:0]   round_count,
   input  logic                          decrypt_mode,
   output logic [cpbc_pkg::HalfW-1:0]    rsp_out_low,
   output logic [cpbc_pkg::HalfW-1:0]    rsp_out_high
);
   import cpbc_pkg::*;

   block_type         d_ff, d_in;
   block_type         t_ff, t_in;
   block_type         k_ff, k_in;
   block_type         chain_ff, chain_in;
   perm_type          perm_ff, perm_in;
   block_type         out_ff, out_in;
   logic              full_ff, full_in;
   logic [SumW-1:0]   sum_ff, sum_in;
   logic [QuotW-1:0]  quot_ff, quot_in;
   logic [RoundW-1:0] shift_ff, shift_in;

   logic [RoundW-1:0] start_amt;
   logic [ProdW-1:0]  prod;
   logic [SumW-1:0]   rem;

   // rounds 0 and 1 key with the chain block as is; more rounds start one byte on
   // (encrypt) or at the last round's key (decrypt)
   always_comb begin
      if (round_count < RoundW'(2)) begin
         start_amt = '0;
      end else if (decrypt_mode) begin
         start_amt = round_count;
      end else begin
         start_amt = RoundW'(1);
      end
   end

   assign prod = ProdW'(sum_ff) * ProdW'(RecipMod);
   assign rem  = sum_ff - SumW'(quot_ff * SumW'(ModBase));

   always_comb begin
      d_in     = d_ff;
      t_in     = t_ff;
      k_in     = k_ff;
      chain_in = chain_ff;
      perm_in  = perm_ff;
      out_in   = out_ff;
      full_in  = full_ff;
      sum_in   = sum_ff;
      quot_in  = quot_ff;
      shift_in = shift_ff;
      if (cmd.load) begin
         d_in    = mask_block({req_block_high, req_block_low}, req_valid_bytes);
         full_in = (req_valid_bytes >= ValidW'(BlockBytes));
         if (req_first_block) begin
            chain_in = {key_high, key_low};
            perm_in  = perm_table;
         end
      end
      if (cmd.setup) begin
         t_in = status.skip ? '0 : d_ff;
         k_in = rotl_bytes(chain_ff, start_amt);
      end
      if (cmd.round) begin
         if (decrypt_mode) begin
            t_in = inv_perm(t_ff, perm_ff) ^ k_ff;
            k_in = rotl_bytes(k_ff, RoundW'(BlockBytes - 1));
         end else begin
            t_in = fwd_perm(t_ff ^ k_ff, perm_ff);
            k_in = rotl_bytes(k_ff, RoundW'(1));
         end
      end
      if (cmd.sum) begin
         sum_in   = byte_sum(decrypt_mode ? t_ff : d_ff);
         chain_in = decrypt_mode ? d_ff : t_ff;
      end
      if (cmd.quot) begin
         quot_in = QuotW'(prod >> RecipShift);
      end
      if (cmd.rem) begin
         shift_in = rem[RoundW-1:0] + RoundW'(1);
      end
      if (cmd.rot) begin
         perm_in = rotl_nibs(perm_ff, shift_ff);
      end
      if (cmd.emit) begin
         out_in = t_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
         perm_ff  <= PermIdentity;
      end else begin
         chain_ff <= chain_in;
         perm_ff  <= perm_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff     <= d_in;
      t_ff     <= t_in;
      k_ff     <= k_in;
      out_ff   <= out_in;
      full_ff  <= full_in;
      sum_ff   <= sum_in;
      quot_ff  <= quot_in;
      shift_ff <= shift_in;
   end

   assign status.skip  = decrypt_mode & ~full_ff;
   assign status.full  = full_ff;
   assign rsp_out_low  = out_ff[HalfW-1:0];
   assign rsp_out_high = out_ff[BlockW-1:HalfW];

endmodule

@@ rtl/core/chained_permutation_block_cipher.sv @@
// Chained permutation block cipher. One 16-byte block is in flight at a time:
// the core runs one round (XOR with the round key and byte permutation) per
// clock. A full block runs the round loop (at least one round) and then the
// four-step table update (byte sum, divide by 13, remainder, nibble rotate); a
// partial encrypt block runs the rounds only, and a partial decrypt block,
// which returns zero, runs no rounds. The next block is taken as soon as the
// core is idle, even if the previous result is still waiting in the output
// register. first_block reloads the chain from the key and the table from
// perm_table. Configuration writes are always ready and must only be issued
// while the core is idle.
// Depends on cpbc_pkg, cpbc_ctrl and cpbc_dp.
module chained_permutation_block_cipher (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cpbc_pkg::HalfW-1:0]    req_block_low,
   input  logic [cpbc_pkg::HalfW-1:0]    req_block_high,
   input  logic [cpbc_pkg::ValidW-1:0]   req_valid_bytes,
   input  logic                          req_first_block,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cpbc_pkg::HalfW-1:0]    rsp_out_low,
   output logic [cpbc_pkg::HalfW-1:0]    rsp_out_high,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cpbc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [cpbc_pkg::CsrDataW-1:0] csr_data
);
   import cpbc_pkg::*;

   logic [HalfW-1:0]  key_low_ff, key_low_in;
   logic [HalfW-1:0]  key_high_ff, key_high_in;
   perm_type          perm_table_ff, perm_table_in;
   logic [RoundW-1:0] round_count_ff, round_count_in;
   logic              decrypt_mode_ff, decrypt_mode_in;

   logic [RoundW-1:0] rounds_eff;
   cmd_type           cmd;
   status_type        status;

   assign csr_ready = 1'b1;

   always_comb begin
      key_low_in      = key_low_ff;
      key_high_in     = key_high_ff;
      perm_table_in   = perm_table_ff;
      round_count_in  = round_count_ff;
      decrypt_mode_in = decrypt_mode_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrKeyLow:     key_low_in      = csr_data[HalfW-1:0];
            CsrKeyHigh:    key_high_in     = csr_data[HalfW-1:0];
            CsrPermTable:  perm_table_in   = csr_data[PermW-1:0];
            CsrRoundCount: round_count_in  = csr_data[RoundW-1:0];
            CsrDecrypt:    decrypt_mode_in = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff      <= '0;
         key_high_ff     <= '0;
         perm_table_ff   <= PermIdentity;
         round_count_ff  <= RoundW'(1);
         decrypt_mode_ff <= 1'b0;
      end else begin
         key_low_ff      <= key_low_in;
         key_high_ff     <= key_high_in;
         perm_table_ff   <= perm_table_in;
         round_count_ff  <= round_count_in;
         decrypt_mode_ff <= decrypt_mode_in;
      end
   end

   // zero rounds behaves as one
   assign rounds_eff = (round_count_ff == '0) ? RoundW'(1) : round_count_ff;

   cpbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rounds_eff (rounds_eff),
      .status     (status),
      .cmd        (cmd)
   );

   cpbc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_block_low   (req_block_low),
      .req_block_high  (req_block_high),
      .req_valid_bytes (req_valid_bytes),
      .req_first_block (req_first_block),
      .key_low         (key_low_ff),
      .key_high        (key_high_ff),
      .perm_table      (perm_table_ff),
      .round_count     (round_count_ff),
      .decrypt_mode    (decrypt_mode_ff),
      .rsp_out_low     (rsp_out_low),
      .rsp_out_high    (rsp_out_high)
   );

endmodule

@@ rtl/core/cpbc_checker.sv @@
// Port-level checks for the chained permutation block cipher, bound to the top level.
// Depends on cpbc_pkg and chained_permutation_block_cipher.
module cpbc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [cpbc_pkg::HalfW-1:0] rsp_out_low,
   input logic [cpbc_pkg::HalfW-1:0] rsp_out_high
);
   import cpbc_pkg::*;

   // one block at a time: the core is busy right after an input transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("core idle straight after an input transfer");

   // a result only appears after the core has been busy
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised without work in progress");

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result valid dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_low) && $stable(rsp_out_high))
      else $error("result payload changed while stalled");

endmodule

bind chained_permutation_block_cipher cpbc_checker u_cpbc_checker (.*);
